### design/right_aligned_base64_decoder_macros.svh
// Assertion helpers for the right-aligned base64 decoder.
`ifndef RIGHT_ALIGNED_BASE64_DECODER_MACROS_SVH
`define RIGHT_ALIGNED_BASE64_DECODER_MACROS_SVH

// Checked on every clock edge outside of reset.
`define RABD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RABD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/rabd_pkg.sv
`default_nettype none

package rabd_pkg;

   localparam int MAX_SEXTETS_DEFAULT = 64;
   localparam int CHAR_W              = 8;
   localparam int SEXTET_W            = 6;
   localparam int BYTE_W              = 8;

   localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;

   localparam logic [SEXTET_W-1:0] VAL_UPPER_BASE = 6'd10;
   localparam logic [SEXTET_W-1:0] VAL_LOWER_BASE = 6'd36;
   localparam logic [SEXTET_W-1:0] VAL_DOT        = 6'd62;
   localparam logic [SEXTET_W-1:0] VAL_SLASH      = 6'd63;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DRAIN,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic                hit;
      logic [SEXTET_W-1:0] value;
   } sym_type;

   // Alphabet lookup: 0-9, A-Z, a-z, '.', '/'.
   function automatic sym_type sym_decode(input logic [CHAR_W-1:0] c);
      sym_type           res;
      logic [CHAR_W-1:0] diff;
      res.hit   = 1'b0;
      res.value = '0;
      diff      = '0;
      if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
         diff      = c - CH_DIGIT_0;
         res.hit   = 1'b1;
         res.value = diff[SEXTET_W-1:0];
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         diff      = c - CH_UPPER_A;
         res.hit   = 1'b1;
         res.value = diff[SEXTET_W-1:0] + VAL_UPPER_BASE;
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         diff      = c - CH_LOWER_A;
         res.hit   = 1'b1;
         res.value = diff[SEXTET_W-1:0] + VAL_LOWER_BASE;
      end else if (c == CH_DOT) begin
         res.hit   = 1'b1;
         res.value = VAL_DOT;
      end else if (c == CH_SLASH) begin
         res.hit   = 1'b1;
         res.value = VAL_SLASH;
      end
      return res;
   endfunction

   // Bits of the first stored value that survive the right alignment,
   // by stored count modulo four.
   function automatic logic [2:0] first_keep(input logic [1:0] rem4);
      logic [2:0] k;
      case (rem4)
         2'd0:    k = 3'd6;
         2'd1:    k = 3'd0;
         2'd2:    k = 3'd2;
         2'd3:    k = 3'd4;
         default: k = 3'd6;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

### design/right_aligned_base64_decoder.sv
`default_nettype none

// Right-aligned base64 decoder (alphabet 0-9, A-Z, a-z, '.', '/'). Characters
// are taken one per cycle while loading; characters outside the alphabet are
// skipped, and valid ones beyond MAX_SEXTETS are dropped and reported through
// rsp_overflowed on every result of that text. After the character marked
// req_last_char the stored values are read back one per cycle, while the
// result side does not stall, through the store's single read port and
// packed into bytes; req_ready stays low during the drain and rises once the
// final stored value has been consumed. A text with fewer than two stored
// values yields one result with rsp_no_data set and rsp_byte_value zero. The
// store needs no clearing after reset: only entries written for the current
// text are read.

`include "right_aligned_base64_decoder_macros.svh"

module right_aligned_base64_decoder #(
   parameter int MAX_SEXTETS = rabd_pkg::MAX_SEXTETS_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire  [rabd_pkg::CHAR_W-1:0] req_char_code,
   input  wire                         req_last_char,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [rabd_pkg::BYTE_W-1:0] rsp_byte_value,
   output logic                        rsp_last_byte,
   output logic                        rsp_no_data,
   output logic                        rsp_overflowed
);

   localparam int CW = $clog2(MAX_SEXTETS + 1);
   localparam int IW = $clog2(MAX_SEXTETS);
   localparam int SW = rabd_pkg::SEXTET_W;
   localparam int BW = rabd_pkg::BYTE_W;

   logic [SW-1:0] store_mem [MAX_SEXTETS];

   rabd_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           ovf_ff, ovf_in;
   logic [CW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic           rd_valid_ff, rd_valid_in;
   logic           rd_first_ff, rd_last_ff;
   logic [SW-1:0]  rd_data_ff;
   logic [2:0]     bits_ff, bits_in;
   logic [SW-1:0]  acc_ff, acc_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]  rsp_byte_ff;
   logic           rsp_last_ff, rsp_none_ff, rsp_ovf_ff;

   rabd_pkg::sym_type sym;
   logic           accept, wr_en, issue, consume, out_free;
   logic           load_out, out_last, out_none;
   logic [BW-1:0]  out_byte;
   logic [IW-1:0]  wr_addr, rd_addr;
   logic [2:0]     keep, rem;
   logic [SW-1:0]  s_masked;
   logic [3:0]     bits_sum, shamt;
   logic [2*SW-1:0] cat;
   logic           emit;

   assign req_ready = (state_ff == rabd_pkg::ST_LOAD);
   assign accept    = req_valid && req_ready;
   assign sym       = rabd_pkg::sym_decode(req_char_code);
   assign wr_en     = accept && sym.hit && (count_ff < CW'(MAX_SEXTETS));
   assign wr_addr   = count_ff[IW-1:0];
   assign rd_addr   = rd_ptr_ff[IW-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign consume   = (state_ff == rabd_pkg::ST_DRAIN) && rd_valid_ff && out_free;
   assign issue     = (state_ff == rabd_pkg::ST_DRAIN) && (rd_ptr_ff < count_ff)
                      && (!rd_valid_ff || consume);

   // Bit packer: the first value keeps only its right-aligned low bits.
   always_comb begin
      keep     = rd_first_ff ? rabd_pkg::first_keep(count_ff[1:0]) : 3'd6;
      s_masked = rd_data_ff & (6'h3f >> (3'd6 - keep));
      bits_sum = {1'b0, bits_ff} + {1'b0, keep};
      cat      = {acc_ff, s_masked};
      emit     = (bits_sum >= 4'd8);
      shamt    = bits_sum - 4'd8;
      out_byte = BW'(cat >> shamt[2:0]);
      rem      = emit ? shamt[2:0] : bits_sum[2:0];
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      rd_ptr_in   = rd_ptr_ff;
      bits_in     = bits_ff;
      acc_in      = acc_ff;
      load_out    = 1'b0;
      out_last    = 1'b0;
      out_none    = 1'b0;
      rd_valid_in = rd_valid_ff;
      if (issue) begin
         rd_ptr_in = rd_ptr_ff + CW'(1);
      end
      if (issue) begin
         rd_valid_in = 1'b1;
      end else if (consume) begin
         rd_valid_in = 1'b0;
      end
      case (state_ff)
         rabd_pkg::ST_LOAD: begin
            if (accept) begin
               if (wr_en) begin
                  count_in = count_ff + CW'(1);
               end else if (sym.hit) begin
                  ovf_in = 1'b1;
               end
               if (req_last_char) begin
                  rd_ptr_in = '0;
                  bits_in   = '0;
                  acc_in    = '0;
                  state_in  = (count_in < CW'(2)) ? rabd_pkg::ST_EMPTY
                                                  : rabd_pkg::ST_DRAIN;
               end
            end
         end
         rabd_pkg::ST_DRAIN: begin
            if (consume) begin
               bits_in  = rem;
               acc_in   = cat[SW-1:0] & (6'h3f >> (3'd6 - rem));
               load_out = emit;
               out_last = rd_last_ff;
               if (rd_last_ff) begin
                  state_in  = rabd_pkg::ST_LOAD;
                  count_in  = '0;
                  ovf_in    = 1'b0;
                  rd_ptr_in = '0;
               end
            end
         end
         rabd_pkg::ST_EMPTY: begin
            if (out_free) begin
               load_out = 1'b1;
               out_last = 1'b1;
               out_none = 1'b1;
               state_in = rabd_pkg::ST_LOAD;
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = rabd_pkg::ST_LOAD;
         end
      endcase
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rabd_pkg::ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rd_ptr_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         bits_ff      <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rd_ptr_ff    <= rd_ptr_in;
         rd_valid_ff  <= rd_valid_in;
         bits_ff      <= bits_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sextet store: one write port while loading, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= sym.value;
      end
      if (issue) begin
         rd_data_ff  <= store_mem[rd_addr];
         rd_first_ff <= (rd_ptr_ff == '0);
         rd_last_ff  <= (rd_ptr_ff == count_ff - CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_byte_ff <= out_none ? '0 : out_byte;
         rsp_last_ff <= out_last;
         rsp_none_ff <= out_none;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_value = rsp_byte_ff;
   assign rsp_last_byte  = rsp_last_ff;
   assign rsp_no_data    = rsp_none_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   `RABD_ASSERT(a_read_only_in_drain, rd_valid_ff |-> state_ff == rabd_pkg::ST_DRAIN, "read data outside drain")
   `RABD_ASSERT(a_ptr_within_count, rd_ptr_ff <= count_ff, "read pointer past stored count")
   `RABD_ASSERT(a_count_within_store, count_ff <= CW'(MAX_SEXTETS), "stored count past capacity")
   `RABD_ASSERT(a_packer_even, state_ff == rabd_pkg::ST_DRAIN |-> bits_ff[0] == 1'b0 && bits_ff <= 3'd6, "packer holds odd or too many bits")
   `RABD_ASSERT(a_empty_is_final, rsp_valid && rsp_no_data |-> rsp_last_byte && rsp_byte_value == '0, "empty result malformed")
   `RABD_ASSERT_ALWAYS(a_reset_clears_valid, reset |=> !rsp_valid, "result valid after reset")

endmodule

`default_nettype wire

### bench/testbench.sv
`default_nettype none

module testbench;

   localparam int STORE_DEPTH  = rabd_pkg::MAX_SEXTETS_DEFAULT;
   localparam int CHAR_BITS    = rabd_pkg::CHAR_W;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 64;

   typedef struct packed {
      logic [rabd_pkg::CHAR_W-1:0] code;
      logic                        last;
   } char_item_type;

   typedef struct packed {
      logic [rabd_pkg::BYTE_W-1:0] value;
      logic                        last;
      logic                        none;
      logic                        ovf;
   } byte_result_type;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic [rabd_pkg::CHAR_W-1:0]   req_char_code  = '0;
   logic                          req_last_char  = 1'b0;
   logic                          rsp_ready      = 1'b0;
   wire                           req_ready;
   wire                           rsp_valid;
   wire  [rabd_pkg::BYTE_W-1:0]   rsp_byte_value;
   wire                           rsp_last_byte;
   wire                           rsp_no_data;
   wire                           rsp_overflowed;

   right_aligned_base64_decoder u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .req_last_char  (req_last_char),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte_value (rsp_byte_value),
      .rsp_last_byte  (rsp_last_byte),
      .rsp_no_data    (rsp_no_data),
      .rsp_overflowed (rsp_overflowed)
   );

   always #2 clock = ~clock;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   string alphabet_chars =
      "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz./";

   // decoder state as seen by the predictor
   logic [rabd_pkg::SEXTET_W-1:0] sextets [STORE_DEPTH];
   int                            sextet_total = 0;
   logic                          dropped_flag = 1'b0;

   char_item_type   char_backlog[$];
   byte_result_type expected_bytes[$];

   int  sender_idle_pct    = 0;
   int  receiver_stall_pct = 0;
   bit  hold_trigger       = 1'b0;
   int  error_count        = 0;
   int  chars_sent         = 0;
   int  texts_done         = 0;
   int  bytes_checked      = 0;
   int  empty_seen         = 0;
   int  overflow_seen      = 0;

   function automatic int sextet_of(logic [rabd_pkg::CHAR_W-1:0] c);
      for (int i = 0; i < 64; i++)
         if (alphabet_chars[i] == c) return i;
      return -1;
   endfunction

   // Stores one character; on the final one, packs the store right-aligned
   // into bytes and queues them.
   function automatic void absorb_char(logic [rabd_pkg::CHAR_W-1:0] c, logic fin);
      int                          v;
      int                          r;
      byte_result_type             res;
      logic [rabd_pkg::BYTE_W-1:0] out_bytes[$];
      v = sextet_of(c);
      if (v >= 0) begin
         if (sextet_total < STORE_DEPTH) begin
            sextets[sextet_total] = v[rabd_pkg::SEXTET_W-1:0];
            sextet_total++;
         end else begin
            dropped_flag = 1'b1;
         end
      end
      if (!fin) return;
      texts_done++;
      r = sextet_total % 4;
      if (r == 2) begin
         out_bytes.push_back({sextets[0][1:0], sextets[1]});
      end else if (r == 3) begin
         out_bytes.push_back({sextets[0][3:0], sextets[1][5:2]});
         out_bytes.push_back({sextets[1][1:0], sextets[2]});
      end
      for (int p = r; p + 4 <= sextet_total; p += 4) begin
         out_bytes.push_back({sextets[p], sextets[p+1][5:4]});
         out_bytes.push_back({sextets[p+1][3:0], sextets[p+2][5:2]});
         out_bytes.push_back({sextets[p+2][1:0], sextets[p+3]});
      end
      if (out_bytes.size() == 0) begin
         res.value = '0;
         res.last  = 1'b1;
         res.none  = 1'b1;
         res.ovf   = dropped_flag;
         expected_bytes.push_back(res);
      end else begin
         foreach (out_bytes[i]) begin
            res.value = out_bytes[i];
            res.last  = (i == out_bytes.size() - 1);
            res.none  = 1'b0;
            res.ovf   = dropped_flag;
            expected_bytes.push_back(res);
         end
      end
      sextet_total = 0;
      dropped_flag = 1'b0;
   endfunction

   // request side: one transfer per accepted character
   always @(posedge clock) begin : drive_req
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            absorb_char(req_char_code, req_last_char);
            chars_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid && char_backlog.size() != 0 &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            next_valid = 1'b1;
            req_char_code <= char_backlog[0].code;
            req_last_char <= char_backlog[0].last;
            void'(char_backlog.pop_front());
         end
         req_valid <= next_valid;
      end
   end

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // response side: compare each transfer with the oldest predicted byte
   always @(posedge clock) begin : watch_rsp
      byte_result_type want;
      int              hold_left;
      bit              hold_seen;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         hold_seen = hold_trigger;
      end else begin
         if (rsp_valid && rsp_ready) begin
            bytes_checked++;
            if (rsp_no_data)    empty_seen++;
            if (rsp_overflowed) overflow_seen++;
            if (expected_bytes.size() == 0) begin
               $error("unexpected result: byte_value 0x%0h with nothing pending",
                      rsp_byte_value);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               check_field("byte_value", int'(want.value), int'(rsp_byte_value));
               check_field("last_byte",  int'(want.last),  int'(rsp_last_byte));
               check_field("no_data",    int'(want.none),  int'(rsp_no_data));
               check_field("overflowed", int'(want.ovf),   int'(rsp_overflowed));
            end
         end
         if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results still pending",
                     QUIET_LIMIT, expected_bytes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic void push_char(logic [rabd_pkg::CHAR_W-1:0] c, logic last);
      char_item_type it;
      it.code = c;
      it.last = last;
      char_backlog.push_back(it);
   endfunction

   function automatic void queue_text(string s, bit ends);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i], ends && (i == s.len() - 1));
   endfunction

   function automatic void queue_random_text(int len, int noise_pct);
      logic [rabd_pkg::CHAR_W-1:0] c;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < noise_pct) c = CHAR_BITS'($urandom_range(0, 255));
         else                                   c = alphabet_chars[$urandom_range(0, 63)];
         push_char(c, i == len - 1);
      end
   endfunction

   // mostly short texts, some single characters, a few medium ones
   function automatic void queue_random_items(int target);
      int queued;
      int len;
      int noise;
      queued = 0;
      while (queued < target) begin
         case ($urandom_range(0, 9))
            0:       len = 1;
            1:       len = $urandom_range(16, 40);
            default: len = $urandom_range(2, 10);
         endcase
         noise = ($urandom_range(0, 7) == 0) ? 100 : 12;
         queue_random_text(len, noise);
         queued += len;
      end
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (char_backlog.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      int sender_mix[4];
      int receiver_mix[4];
      sender_mix   = '{0, 63, 0, 19};
      receiver_mix = '{0, 0, 63, 19};

      // directed: empty text, single value, 2/3/4 values, alphabet edges
      // and their neighbors, skipped last character
      push_char(8'h00, 1'b1);
      push_char(8'hFF, 1'b0);
      queue_text("/", 1);
      queue_text("./", 1);
      queue_text("09", 0);
      push_char(8'h80, 1'b0);
      queue_text("A", 1);
      queue_text("Zaz/", 1);
      queue_text("-:@[", 0);
      push_char(8'h60, 1'b0);
      queue_text("{", 0);
      push_char(8'h7F, 1'b0);
      queue_text("0z9.A", 1);
      queue_text("Qr", 0);
      push_char(8'h20, 1'b1);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct    = sender_mix[ph];
         receiver_stall_pct = receiver_mix[ph];
         queue_random_items(6);
         wait_drained();
      end

      // back-pressure: long receiver hold-off while a text one past the
      // store size streams in, then an empty text waits behind the drain
      sender_idle_pct    = 0;
      receiver_stall_pct = 19;
      hold_trigger       = ~hold_trigger;
      queue_random_text(STORE_DEPTH + 1, 0);
      push_char(8'h7E, 1'b1);
      wait_drained();

      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Covered %0d texts from %0d characters: %0d bytes checked,",
               texts_done, chars_sent, bytes_checked);
      $display("%0d empty and %0d overflow results", empty_seen, overflow_seen);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
